>>> rtl/sib_pkg.sv
// Shared types and constants for the sample-in-ball challenge sampler.
package sib_pkg;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_FEED  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} sib_op_t;

	typedef struct packed {
		sib_op_t    opcode;
		logic [7:0] stream_byte;
		logic [7:0] coeff_index;
	} sib_cmd_t;

	typedef struct packed {
		logic signed [1:0] read_value;
		logic [6:0]        placed;
		logic              done_res;
		logic              rejected;
	} sib_res_t;

	localparam int unsigned CAND_BITS    = 9;
	localparam int unsigned WEIGHT_RESET = 60;

	localparam logic signed [1:0] COEFF_ZERO = 2'sb00;
	localparam logic signed [1:0] COEFF_POS  = 2'sb01;
	localparam logic signed [1:0] COEFF_NEG  = 2'sb11;

endpackage

>>> rtl/challenge_sample_in_ball.sv
// Sample-in-ball challenge polynomial sampler with a coefficient RAM of one read and one write port.
// Every beat gives its result in the cycle after it is accepted (res_valid strobe).
// Throughput: one beat per cycle, except that a byte that places a coefficient holds busy
//   through the placement stage (ST_WRPOS) to write back through the one RAM write port.
// Reset (arst_n low) loads weight 60 and starts an empty challenge; the coefficient RAM is
//   cleared at once through per-entry valid bits, no clearing pass. Results cannot stall.
module challenge_sample_in_ball
	import sib_pkg::*;
#(
	parameter int N              = 256,
	parameter int MAX_SIGN_BYTES = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  sib_cmd_t   cmd,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	output logic       res_valid,
	output sib_res_t   res
);

	localparam int AW   = $clog2(N);
	localparam int PW   = $clog2(N + 1);
	localparam int CMPW = (PW > 9) ? PW : 9;
	localparam int SW   = (MAX_SIGN_BYTES > 1) ? $clog2(MAX_SIGN_BYTES) : 1;
	localparam int TW   = $clog2(MAX_SIGN_BYTES + 1);
	localparam int WLIM = (8 * MAX_SIGN_BYTES < N) ? 8 * MAX_SIGN_BYTES : N;

	// Clamp a weight to what the sign bytes and the ring size allow.
	function automatic logic [6:0] clamp_w(input logic [6:0] w);
		if (int'(w) > WLIM) begin
			return 7'(WLIM);
		end
		return w;
	endfunction

	localparam logic [6:0] AW_RESET = clamp_w(7'(WEIGHT_RESET));

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_WRPOS = 2'b10
	} st_t;

	// Control state
	st_t           st_q, st_n;
	logic [6:0]    weight_q;
	logic [6:0]    aw_q, aw_n;
	logic [PW-1:0] pos_q, pos_n;
	logic [6:0]    placed_q, placed_n;
	logic          fin_q, fin_n;
	logic [14:0]   buf_q, buf_n;
	logic [3:0]    cnt_q, cnt_n;
	logic [TW-1:0] taken_q, taken_n;
	logic [N-1:0]  valid_q;

	// Storage
	logic signed [1:0] coeff_mem [N];
	logic [7:0]        sign_mem [MAX_SIGN_BYTES];

	// Placement stage and deferred write of coefficient[b]
	logic [AW-1:0]     pos_s1, b_s1;
	logic              sign_s1;
	logic              pend_q;
	logic [AW-1:0]     pend_addr_q;
	logic signed [1:0] pend_val_q;

	// Read path and result stage
	logic signed [1:0] rdata_s1, fwd_s1;
	logic              hit_s1, vld_s1, is_read_s1;
	logic              res_valid_q, rej_s1, done_s1;
	logic [6:0]        placed_s1;

	// Combinational
	logic              accept, start_clear;
	logic [6:0]        new_aw;
	logic [7:0]        needed;
	logic              sign_phase;
	logic [15:0]       comb_buf;
	logic [4:0]        cnt_sum;
	logic              have_cand;
	logic [8:0]        cand;
	logic              sign_we, place, rej;
	logic [AW-1:0]     raddr;
	logic              read_oob;
	logic signed [1:0] old_b;
	logic              we;
	logic [AW-1:0]     waddr;
	logic signed [1:0] wdata;

	assign accept      = start && !busy;
	assign start_clear = accept && (cmd.opcode == OP_START);
	assign busy        = (st_q == ST_WRPOS);

	assign new_aw     = clamp_w(weight_q);
	assign needed     = (8'(aw_q) + 8'd7) >> 3;
	assign sign_phase = (8'(taken_q) < needed);
	assign comb_buf   = 16'(buf_q) | (16'(cmd.stream_byte) << cnt_q);
	assign cnt_sum    = 5'(cnt_q) + 5'd8;
	assign have_cand  = (cnt_sum >= 5'(CAND_BITS));
	assign cand       = comb_buf[8:0];

	// Advance sampler state for the accepted beat.
	always_comb begin
		aw_n     = aw_q;
		pos_n    = pos_q;
		placed_n = placed_q;
		fin_n    = fin_q;
		buf_n    = buf_q;
		cnt_n    = cnt_q;
		taken_n  = taken_q;
		sign_we  = 1'b0;
		place    = 1'b0;
		rej      = 1'b0;
		if (accept) begin
			unique case (cmd.opcode)
				OP_START: begin
					aw_n     = new_aw;
					pos_n    = PW'(N) - PW'(new_aw);
					placed_n = '0;
					fin_n    = (new_aw == '0);
					buf_n    = '0;
					cnt_n    = '0;
					taken_n  = '0;
				end
				OP_FEED: begin
					if (!fin_q) begin
						if (sign_phase) begin
							sign_we = 1'b1;
							taken_n = taken_q + TW'(1);
						end else if (have_cand) begin
							buf_n = 15'(comb_buf >> CAND_BITS);
							cnt_n = 4'(cnt_sum - 5'(CAND_BITS));
							if (CMPW'(cand) > CMPW'(pos_q)) begin
								rej = 1'b1;
							end else begin
								place    = 1'b1;
								pos_n    = pos_q + PW'(1);
								placed_n = placed_q + 7'd1;
								fin_n    = ((pos_q + PW'(1)) == PW'(N));
							end
						end else begin
							buf_n = comb_buf[14:0];
							cnt_n = cnt_sum[3:0];
						end
					end
				end
				OP_READ, OP_NONE: begin
				end
			endcase
		end
	end

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE:  if (place) st_n = ST_WRPOS;
			ST_WRPOS: st_n = ST_IDLE;
			default:  st_n = ST_IDLE;
		endcase
	end

	// One read address: the read index for reads, the candidate otherwise.
	assign raddr    = (cmd.opcode == OP_READ) ? AW'(cmd.coeff_index) : AW'(cand);
	assign read_oob = (10'(cmd.coeff_index) >= 10'(N));

	// Old coefficient[b], with the deferred write forwarded and unwritten entries as zero.
	assign old_b = hit_s1 ? fwd_s1 : (vld_s1 ? rdata_s1 : COEFF_ZERO);

	// Write port: position during the placement stage, else the deferred b write.
	always_comb begin
		if (st_q == ST_WRPOS) begin
			we    = 1'b1;
			waddr = pos_s1;
			wdata = old_b;
		end else begin
			we    = pend_q && !start_clear;
			waddr = pend_addr_q;
			wdata = pend_val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			coeff_mem[waddr] <= wdata;
		end
		rdata_s1 <= coeff_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (sign_we) begin
			sign_mem[SW'(taken_q)] <= cmd.stream_byte;
		end
	end

	// Payload stage registers
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_s1     <= pend_q && (pend_addr_q == raddr);
			fwd_s1     <= pend_val_q;
			vld_s1     <= valid_q[raddr];
			is_read_s1 <= (cmd.opcode == OP_READ) && !read_oob;
			placed_s1  <= placed_n;
			done_s1    <= fin_n;
			rej_s1     <= rej;
		end
		if (place) begin
			pos_s1  <= AW'(pos_q);
			b_s1    <= AW'(cand);
			sign_s1 <= sign_mem[SW'(placed_q >> 3)][placed_q[2:0]];
		end
		if (st_q == ST_WRPOS) begin
			pend_addr_q <= b_s1;
			pend_val_q  <= sign_s1 ? COEFF_NEG : COEFF_POS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			weight_q    <= 7'(WEIGHT_RESET);
			aw_q        <= AW_RESET;
			pos_q       <= PW'(N) - PW'(AW_RESET);
			placed_q    <= '0;
			fin_q       <= (AW_RESET == '0);
			buf_q       <= '0;
			cnt_q       <= '0;
			taken_q     <= '0;
			valid_q     <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			st_q        <= st_n;
			aw_q        <= aw_n;
			pos_q       <= pos_n;
			placed_q    <= placed_n;
			fin_q       <= fin_n;
			buf_q       <= buf_n;
			cnt_q       <= cnt_n;
			taken_q     <= taken_n;
			res_valid_q <= accept;
			pend_q      <= (st_q == ST_WRPOS);
			if (cfg_we) begin
				weight_q <= cfg_wdata;
			end
			// Drop the whole store on a start; otherwise mark written entries.
			if (start_clear) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	assign res_valid = res_valid_q;

	always_comb begin
		res.read_value = is_read_s1 ? old_b : COEFF_ZERO;
		res.placed     = placed_s1;
		res.done_res   = done_s1;
		res.rejected   = rej_s1;
	end

	// A placement stage always shows the result of the byte that opened it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WRPOS) |-> res_valid_q)
		else $error("placement stage without result strobe");

	// The placement stage is always followed directly by idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WRPOS) |=> (st_q == ST_IDLE))
		else $error("placement stage held");

	// The deferred write never competes with the position write.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_q && (st_q == ST_WRPOS)))
		else $error("write port conflict");

	// Never place more coefficients than the latched weight.
	assert property (@(posedge clk) disable iff (!arst_n)
		placed_q <= aw_q)
		else $error("placed count beyond weight");

	// Finished exactly when the position has reached the ring end.
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_q == (pos_q == PW'(N)))
		else $error("finished flag out of step with position");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the sample-in-ball challenge sampler.
`timescale 1ns / 100ps

module tb;
	import sib_pkg::*;

	localparam int          N_COEF        = 256;
	localparam int          MAX_SIGN      = 15;
	localparam int unsigned CAND_MASK     = 'h1ff;
	localparam int unsigned BUF_MASK      = 'h7fff;
	localparam int unsigned SIGN_BIT_MASK = 7;
	localparam int          TARGET_BEATS  = 950;
	localparam int          LIMIT_CYCLES  = 400000;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	sib_cmd_t   cmd;
	logic       cfg_we;
	logic [6:0] cfg_wdata;
	logic       res_valid;
	sib_res_t   res;

	challenge_sample_in_ball #(
		.N(N_COEF),
		.MAX_SIGN_BYTES(MAX_SIGN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.res_valid(res_valid),
		.res(res)
	);

	always #10 clk = ~clk;

	// Shadow copy of the sampler: coefficient store, sign bytes, bit packer, placement.
	logic signed [1:0] ball [N_COEF];
	logic [7:0]        sign_mem [MAX_SIGN];
	int unsigned       bit_acc;
	int unsigned       bit_cnt;
	int unsigned       signs_taken;
	int unsigned       pos;
	int unsigned       act_w;
	int unsigned       w_reg;
	bit                ch_done;

	// Results waiting for the block, oldest first.
	sib_res_t expect_q [$];
	sib_res_t want;

	int  errors;
	int  n_checked;
	int  beats_sent;
	int  n_challenges;
	int  cycles;
	int  burst_left;
	bit  pace_on;

	function automatic int unsigned clamp_weight(input int unsigned w);
		if (w > 8 * MAX_SIGN)
			w = 8 * MAX_SIGN;
		if (w > N_COEF)
			w = N_COEF;
		return w;
	endfunction

	// Latch the weight register and clear the store, the packer and the counters.
	function automatic void new_challenge();
		foreach (ball[i])
			ball[i] = COEFF_ZERO;
		foreach (sign_mem[i])
			sign_mem[i] = 8'h00;
		bit_acc     = 0;
		bit_cnt     = 0;
		signs_taken = 0;
		act_w       = clamp_weight(w_reg);
		pos         = N_COEF - act_w;
		ch_done     = (act_w == 0);
	endfunction

	// Take one stream byte; return 1 when it completes a rejected candidate.
	function automatic bit absorb_byte(input int unsigned sbyte);
		int unsigned cand;
		int unsigned idx;
		bit          sgn;
		if (ch_done)
			return 1'b0;
		// The leading ceil(weight/8) bytes are sign bits, not candidates.
		if (signs_taken < ((act_w + 7) >> 3)) begin
			if (signs_taken < MAX_SIGN)
				sign_mem[signs_taken] = sbyte[7:0];
			signs_taken++;
			return 1'b0;
		end
		bit_acc |= (sbyte & 'hff) << (bit_cnt & 15);
		bit_cnt += 8;
		if (bit_cnt < CAND_BITS)
			return 1'b0;
		cand    = bit_acc & CAND_MASK;
		bit_acc = (bit_acc >> CAND_BITS) & BUF_MASK;
		bit_cnt -= CAND_BITS;
		if (cand > pos || pos >= N_COEF)
			return 1'b1;
		// Swap: the current slot takes the old value at cand, cand takes the sign.
		ball[pos] = ball[cand];
		idx = pos - (N_COEF - act_w);
		sgn = 1'b0;
		if ((idx >> 3) < MAX_SIGN)
			sgn = sign_mem[idx >> 3][idx & SIGN_BIT_MASK];
		ball[cand] = sgn ? COEFF_NEG : COEFF_POS;
		pos++;
		if (pos >= N_COEF)
			ch_done = 1'b1;
		return 1'b0;
	endfunction

	function automatic sib_res_t predict_result(input sib_cmd_t c);
		sib_res_t r;
		r = '0;
		case (c.opcode)
			OP_START: begin
				new_challenge();
			end
			OP_FEED: begin
				r.rejected = absorb_byte(32'(c.stream_byte));
			end
			OP_READ: begin
				if (c.coeff_index < N_COEF)
					r.read_value = ball[c.coeff_index];
			end
			OP_NONE: begin
			end
		endcase
		r.placed   = 7'(pos - (N_COEF - act_w));
		r.done_res = ch_done;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		errors++;
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
	endtask

	// Compare every strobed result with the oldest expectation; the block cannot stall.
	always @(posedge clk) begin
		if (arst_n && res_valid) begin
			if (expect_q.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = expect_q.pop_front();
				n_checked++;
				if (res.read_value !== want.read_value)
					report_mismatch("read_value", int'(res.read_value), int'(want.read_value));
				if (res.placed !== want.placed)
					report_mismatch("placed", int'(res.placed), int'(want.placed));
				if (res.done_res !== want.done_res)
					report_mismatch("done_res", int'(res.done_res), int'(want.done_res));
				if (res.rejected !== want.rejected)
					report_mismatch("rejected", int'(res.rejected), int'(want.rejected));
			end
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("challenge_sample_in_ball regression: fail");
			$finish;
		end
	end

	// Sender pacing: bursts of random length with random gaps between them.
	task automatic pace();
		int gap;
		if (!pace_on)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 24);
		gap = $urandom_range(0, 7);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drive one beat, hold it until accepted, then log what the block must answer.
	task automatic send_beat(input sib_op_t op, input logic [7:0] sbyte,
			input logic [7:0] idx);
		sib_cmd_t c;
		bit       ignored;
		pace();
		c.opcode      = op;
		c.stream_byte = sbyte;
		c.coeff_index = idx;
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		ignored = (op == OP_NONE) || (op == OP_FEED && ch_done);
		if (op == OP_START)
			n_challenges++;
		expect_q.push_back(predict_result(c));
		if (!ignored)
			beats_sent++;
	endtask

	// Drop start and wait until every expected result is in and the write-back is over.
	task automatic settle();
		start <= 1'b0;
		while (expect_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the weight register; call only while the block is idle.
	task automatic set_weight(input logic [6:0] w);
		cfg_we    <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		w_reg = w;
		cfg_we <= 1'b0;
	endtask

	// Reads and the spare opcode on the empty challenge left by reset.
	task automatic test_idle_ops();
		send_beat(OP_READ, 8'h00, 8'h00);
		send_beat(OP_READ, 8'hff, 8'hff);
		send_beat(OP_NONE, 8'hff, 8'hff);
		settle();
	endtask

	// Weight one: a rejected candidate, an accepted one, then a byte after completion.
	task automatic test_single_weight();
		set_weight(7'd1);
		send_beat(OP_START, 8'h00, 8'h00);
		send_beat(OP_FEED, 8'hff, 8'h00);
		send_beat(OP_FEED, 8'hff, 8'h00);
		send_beat(OP_FEED, 8'hff, 8'h00);
		send_beat(OP_FEED, 8'h00, 8'hff);
		send_beat(OP_FEED, 8'haa, 8'h00);
		send_beat(OP_READ, 8'h00, 8'd127);
		send_beat(OP_READ, 8'h00, 8'hff);
		settle();
	endtask

	// Weight zero: finished at start, bytes ignored, store stays clear.
	task automatic test_zero_weight();
		set_weight(7'd0);
		send_beat(OP_START, 8'hff, 8'hff);
		send_beat(OP_FEED, 8'hff, 8'h00);
		send_beat(OP_READ, 8'h00, 8'hff);
		settle();
	endtask

	// Largest register value saturates at the sign-byte capacity.
	task automatic test_weight_clamp();
		set_weight(7'd127);
		send_beat(OP_START, 8'h00, 8'h00);
		send_beat(OP_FEED, 8'h55, 8'h00);
		send_beat(OP_FEED, 8'haa, 8'h00);
		settle();
	endtask

	// A weight written mid-challenge must wait for the next start.
	task automatic test_late_weight_write();
		set_weight(7'd8);
		send_beat(OP_START, 8'h00, 8'h00);
		send_beat(OP_FEED, 8'h00, 8'h00);
		settle();
		set_weight(7'd100);
		send_beat(OP_FEED, 8'h00, 8'h00);
		send_beat(OP_FEED, 8'h00, 8'h00);
		send_beat(OP_READ, 8'h00, 8'h00);
		settle();
	endtask

	// Full challenges with random content, sprinkled with reads, restarts and noise.
	task automatic test_random_challenges();
		int          pick;
		int          extra;
		logic [6:0]  w;
		while (beats_sent < TARGET_BEATS) begin
			settle();
			pace_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 5) != 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					w = 7'($urandom_range(1, 24));
				else if (pick < 75)
					w = 7'($urandom_range(25, 64));
				else if (pick < 88)
					w = 7'($urandom_range(65, 120));
				else if (pick < 94)
					w = 7'($urandom_range(121, 127));
				else
					w = 7'd0;
				set_weight(w);
			end
			send_beat(OP_START, 8'($urandom), 8'($urandom));
			while (!ch_done && beats_sent < TARGET_BEATS) begin
				pick = $urandom_range(0, 999);
				if (pick < 880) begin
					send_beat(OP_FEED, 8'($urandom), 8'($urandom));
				end else if (pick < 960) begin
					send_beat(OP_READ, 8'($urandom), 8'($urandom));
				end else if (pick < 975) begin
					send_beat(OP_NONE, 8'($urandom), 8'($urandom));
				end else if (pick < 985) begin
					// Broken sequence: restart in the middle of a challenge.
					send_beat(OP_START, 8'($urandom), 8'($urandom));
				end else if (pick < 993) begin
					// Hold off until the block has answered everything.
					settle();
				end else begin
					// Late register write, effective only at the next start.
					settle();
					set_weight(7'($urandom));
				end
			end
			extra = $urandom_range(0, 3);
			repeat (extra)
				send_beat(OP_FEED, 8'($urandom), 8'($urandom));
			repeat ($urandom_range(4, 12)) begin
				if ($urandom_range(0, 1) != 0)
					send_beat(OP_READ, 8'($urandom),
						8'($urandom_range(N_COEF - act_w, N_COEF - 1)));
				else
					send_beat(OP_READ, 8'($urandom), 8'($urandom));
			end
		end
		settle();
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		cmd        = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		errors     = 0;
		n_checked  = 0;
		beats_sent = 0;
		cycles     = 0;
		burst_left = 0;
		pace_on    = 1'b1;
		n_challenges = 0;
		w_reg      = WEIGHT_RESET;
		new_challenge();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_ops();
		test_single_weight();
		test_zero_weight();
		test_weight_clamp();
		test_late_weight_write();
		test_random_challenges();

		$display("Covered %0d counted beats over %0d challenge starts; %0d results checked.",
			beats_sent, n_challenges, n_checked);
		$display("Weights 0, 1, 8, 100, 127 and random settings; %0d mismatches.", errors);
		if (errors == 0) begin
			$display("challenge_sample_in_ball regression: pass");
		end else begin
			$display("challenge_sample_in_ball regression: fail");
		end
		$finish;
	end

endmodule
